>>> rtl/bucketized_group_count_hash_core_macros.svh
// Assertion macros shared by the hash core RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef BUCKETIZED_GROUP_COUNT_HASH_CORE_MACROS_SVH
`define BUCKETIZED_GROUP_COUNT_HASH_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property at every clock edge outside reset
`define BGHC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle
`define BGHC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define BGHC_ASSERT(lbl, clk, rst, prop, msg)
`define BGHC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

>>> rtl/bghc_pkg.sv
`timescale 1ns / 1ps

package bghc_pkg;

   // Fixed field widths
   localparam int KEY_W    = 32;
   localparam int CNT_W    = 32;
   localparam int START_W  = 8;
   localparam int CSR_W    = 9;
   localparam int STATUS_W = 2;
   localparam int STEP_W   = $clog2(START_W);

   // Request codes
   localparam logic REQ_COUNT  = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_KEY  = 2'd3;

   // One table slot: key (zero when empty) and its count
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [CNT_W-1:0] count;
   } slot_type;

   // Status of the shared remainder unit
   typedef struct packed {
      logic busy;
      logic done;
   } rem_status_type;

   // Sequencer states
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_MOD,
      S_READ,
      S_CHECK,
      S_WRITE,
      S_RESP
   } state_type;

endpackage

>>> rtl/bghc_slot_ram.sv
`timescale 1ns / 1ps

module bghc_slot_ram #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic              clock,
   input  logic [AW-1:0]     addr,
   input  logic              we,
   input  bghc_pkg::slot_type wdata,
   output bghc_pkg::slot_type rdata
);
   import bghc_pkg::*;

   slot_type mem [DEPTH];
   slot_type rdata_ff;

   // Write one slot, read one slot with registered data
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/bghc_rem_unit.sv
`timescale 1ns / 1ps
`include "bucketized_group_count_hash_core_macros.svh"

module bghc_rem_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bghc_pkg::START_W-1:0] dividend,
   input  logic [bghc_pkg::CSR_W-1:0]   divisor,
   output logic [bghc_pkg::START_W-1:0] remainder,
   output bghc_pkg::rem_status_type     status
);
   import bghc_pkg::*;

   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(START_W - 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [START_W-1:0]  rem_ff, rem_in;
   logic [START_W-1:0]  shift_ff, shift_in;
   logic [CSR_W-1:0]    trial;
   logic [CSR_W-1:0]    diff;
   logic                fits;

   // Shared subtract and compare: one quotient bit per cycle
   assign trial = {rem_ff, shift_ff[START_W-1]};
   assign diff  = trial - divisor;
   assign fits  = trial >= divisor;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      rem_in   = rem_ff;
      shift_in = shift_ff;
      if (start) begin
         busy_in  = 1'b1;
         step_in  = STEP_LAST;
         rem_in   = '0;
         shift_in = dividend;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[START_W-1:0] : trial[START_W-1:0];
         shift_in = {shift_ff[START_W-2:0], 1'b0};
         step_in  = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Hold the partial remainder and the dividend bits still to shift in
   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
   end

   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   `BGHC_ASSERT(a_done_not_busy, clock, reset, done_ff |-> !busy_ff, "remainder done while busy")
   `BGHC_ASSERT(a_rem_below, clock, reset, done_ff |-> ({1'b0, rem_ff} < divisor), "remainder not below divisor")
   `BGHC_ASSERT_NEXT(a_start_busy, clock, reset, start, busy_ff, "remainder unit did not start")

endmodule

>>> rtl/bucketized_group_count_hash_core.sv
`timescale 1ns / 1ps
`include "bucketized_group_count_hash_core_macros.svh"

// Group-count hash table with bucketized linear probing.
// req_ channel: req_type (count or look up), req_key, req_start_bucket from
// an external hash. rsp_ channel: rsp_count and rsp_status, one transaction
// per request. Both channels move a transaction when valid is high and stall
// is low. csr_ channel writes buckets_in_use (zero reads as one, values above
// BUCKETS clamp to BUCKETS); csr_ready is always high.
// After reset the slot memory, BUCKETS * SLOTS_PER_BUCKET slots (4096 by
// default), is cleared one slot per cycle; req_stall stays high until then.
// One request is worked on at a time with one memory port: each probed slot
// takes a read state and a compare state, and an insert adds a write state.
// A count reads every slot of a bucket before it inserts or moves on, and
// stops early on a hit; a lookup stops at a hit, empty slot or full wrap.
// A start bucket at or above buckets_in_use is first reduced modulo
// buckets_in_use in the remainder unit. A zero key goes straight to the
// result. A finished result waits in an output register while rsp_stall is
// high; the next request is still taken once the core is back to idle.
module bucketized_group_count_hash_core #(
   parameter int BUCKETS          = 256,
   parameter int SLOTS_PER_BUCKET = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic [bghc_pkg::KEY_W-1:0]    req_key,
   input  logic [bghc_pkg::START_W-1:0]  req_start_bucket,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bghc_pkg::CNT_W-1:0]    rsp_count,
   output logic [bghc_pkg::STATUS_W-1:0] rsp_status,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bghc_pkg::CSR_W-1:0]    csr_data
);
   import bghc_pkg::*;

   localparam int TOTAL = BUCKETS * SLOTS_PER_BUCKET;
   localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
   localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int SW    = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
   localparam int BIW   = ($clog2(BUCKETS + 1) > CSR_W) ? $clog2(BUCKETS + 1) : CSR_W;

   localparam logic [BIW-1:0] BIU_MAX   = BIW'(BUCKETS);
   localparam logic [SW-1:0]  SLOT_LAST = SW'(SLOTS_PER_BUCKET - 1);
   localparam logic [AW-1:0]  ADDR_LAST = AW'(TOTAL - 1);

   state_type             state_ff, state_in;
   logic [BIW-1:0]        biu_ff, biu_in;
   logic                  op_ff, op_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [BW-1:0]         start_ff, start_in;
   logic [BW-1:0]         bucket_ff, bucket_in;
   logic [SW-1:0]         slot_ff, slot_in;
   logic                  have_free_ff, have_free_in;
   logic [SW-1:0]         free_slot_ff, free_slot_in;
   logic [AW-1:0]         clr_addr_ff, clr_addr_in;
   logic [CNT_W-1:0]      res_count_ff, res_count_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   logic                  req_accept;
   logic                  start_in_range;
   logic                  key_hit;
   logic                  key_empty;
   logic                  slot_last;
   logic [BIW-1:0]        bucket_inc;
   logic [BW-1:0]         next_bucket;
   logic                  back_at_start;
   logic                  rsp_load;
   logic [CSR_W-1:0]      csr_value;
   logic [BIW-1:0]        csr_ext;

   logic [AW-1:0]         mem_addr;
   logic                  mem_we;
   slot_type              mem_wdata;
   slot_type              mem_rdata;

   logic                  rem_start;
   logic [START_W-1:0]    rem_value;
   rem_status_type        rem_stat;

   // Slot memory and the shared remainder unit
   bghc_slot_ram #(
      .DEPTH (TOTAL),
      .AW    (AW)
   ) u_slot_ram (
      .clock (clock),
      .addr  (mem_addr),
      .we    (mem_we),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   bghc_rem_unit u_rem_unit (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (req_start_bucket),
      .divisor   (biu_ff[CSR_W-1:0]),
      .remainder (rem_value),
      .status    (rem_stat)
   );

   // Probe compare and position stepping
   assign req_accept     = req_valid && !req_stall;
   assign start_in_range = BIW'(req_start_bucket) < biu_ff;
   assign key_hit        = mem_rdata.key == key_ff;
   assign key_empty      = mem_rdata.key == '0;
   assign slot_last      = slot_ff == SLOT_LAST;
   assign bucket_inc     = BIW'(bucket_ff) + BIW'(1);
   assign next_bucket    = (bucket_inc >= biu_ff) ? '0 : BW'(bucket_inc);
   assign back_at_start  = next_bucket == start_ff;
   assign rsp_load       = (state_ff == S_RESP) && (!rsp_valid_ff || !rsp_stall);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_addr_ff == ADDR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               if (req_key == '0) begin
                  state_in = S_RESP;
               end else if (start_in_range) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_MOD;
               end
            end
         end
         S_MOD: begin
            if (rem_stat.done) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (op_ff == REQ_LOOKUP) begin
               if (key_hit || key_empty || (slot_last && back_at_start)) begin
                  state_in = S_RESP;
               end else begin
                  state_in = S_READ;
               end
            end else begin
               if (key_hit) begin
                  state_in = S_RESP;
               end else if (slot_last && (have_free_ff || key_empty)) begin
                  state_in = S_WRITE;
               end else if (slot_last && back_at_start) begin
                  state_in = S_RESP;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_WRITE: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Memory port, remainder start and input stall
   always_comb begin
      req_stall = state_ff != S_IDLE;
      rem_start = (state_ff == S_IDLE) && req_accept && (req_key != '0) && !start_in_range;
      mem_addr  = AW'(32'(bucket_ff) * SLOTS_PER_BUCKET + 32'(slot_ff));
      mem_we    = 1'b0;
      mem_wdata = '0;
      case (state_ff)
         S_CLEAR: begin
            mem_addr = clr_addr_ff;
            mem_we   = 1'b1;
         end
         S_CHECK: begin
            mem_we          = (op_ff == REQ_COUNT) && key_hit;
            mem_wdata.key   = key_ff;
            mem_wdata.count = mem_rdata.count + CNT_W'(1);
         end
         S_WRITE: begin
            mem_we          = 1'b1;
            mem_wdata.key   = key_ff;
            mem_wdata.count = CNT_W'(1);
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // Probe bookkeeping and result
   always_comb begin
      op_in         = op_ff;
      key_in        = key_ff;
      start_in      = start_ff;
      bucket_in     = bucket_ff;
      slot_in       = slot_ff;
      have_free_in  = have_free_ff;
      free_slot_in  = free_slot_ff;
      clr_addr_in   = clr_addr_ff;
      res_count_in  = res_count_ff;
      res_status_in = res_status_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
         end
         S_IDLE: begin
            if (req_accept) begin
               op_in         = req_type;
               key_in        = req_key;
               slot_in       = '0;
               have_free_in  = 1'b0;
               start_in      = BW'(req_start_bucket);
               bucket_in     = BW'(req_start_bucket);
               res_count_in  = '0;
               res_status_in = STATUS_ZERO_KEY;
            end
         end
         S_MOD: begin
            if (rem_stat.done) begin
               start_in  = BW'(rem_value);
               bucket_in = BW'(rem_value);
            end
         end
         S_CHECK: begin
            if (op_ff == REQ_LOOKUP) begin
               // Walk slot by slot; stop on a match, an empty slot or a full wrap
               slot_in = slot_last ? '0 : slot_ff + SW'(1);
               if (slot_last) begin
                  bucket_in = next_bucket;
               end
               if (key_hit) begin
                  res_count_in  = mem_rdata.count;
                  res_status_in = STATUS_DONE;
               end else begin
                  res_count_in  = '0;
                  res_status_in = STATUS_NOT_FOUND;
               end
            end else if (key_hit) begin
               res_count_in  = mem_rdata.count + CNT_W'(1);
               res_status_in = STATUS_DONE;
            end else begin
               // Remember the lowest free slot of this bucket
               if (key_empty && !have_free_ff) begin
                  have_free_in = 1'b1;
                  free_slot_in = slot_ff;
               end
               if (!slot_last) begin
                  slot_in = slot_ff + SW'(1);
               end else if (have_free_ff) begin
                  slot_in = free_slot_ff;
               end else if (key_empty) begin
                  slot_in = slot_ff;
               end else begin
                  slot_in       = '0;
                  bucket_in     = next_bucket;
                  res_count_in  = '0;
                  res_status_in = STATUS_FULL;
               end
            end
         end
         S_WRITE: begin
            res_count_in  = CNT_W'(1);
            res_status_in = STATUS_DONE;
         end
         default: begin
            clr_addr_in = clr_addr_ff;
         end
      endcase
   end

   // Configuration write with clamping
   assign csr_ready = 1'b1;
   assign csr_value = csr_data;
   assign csr_ext   = BIW'(csr_value);

   always_comb begin
      biu_in = biu_ff;
      if (csr_valid && csr_ready) begin
         if (csr_ext == '0) begin
            biu_in = BIW'(1);
         end else if (csr_ext > BIU_MAX) begin
            biu_in = BIU_MAX;
         end else begin
            biu_in = csr_ext;
         end
      end
   end

   // Output register: load when empty or draining, hold while stalled
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_count_in  = res_count_ff;
         rsp_status_in = res_status_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         biu_ff       <= BIU_MAX;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         biu_ff       <= biu_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      start_ff      <= start_in;
      bucket_ff     <= bucket_in;
      slot_ff       <= slot_in;
      have_free_ff  <= have_free_in;
      free_slot_ff  <= free_slot_in;
      res_count_ff  <= res_count_in;
      res_status_ff <= res_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_status = rsp_status_ff;

   `BGHC_ASSERT(a_we_states, clock, reset,
      mem_we |-> (state_ff == S_CLEAR || state_ff == S_CHECK || state_ff == S_WRITE),
      "memory write outside clear or probe")
   `BGHC_ASSERT(a_bucket_range, clock, reset,
      (state_ff == S_READ) |-> (BIW'(bucket_ff) < biu_ff),
      "probe bucket out of range")
   `BGHC_ASSERT(a_rsp_from_resp, clock, reset,
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP),
      "response raised outside result state")
   `BGHC_ASSERT(a_mod_active, clock, reset,
      (state_ff == S_MOD) |-> (rem_stat.busy || rem_stat.done),
      "remainder unit idle while waiting on it")
   `BGHC_ASSERT_NEXT(a_clear_quiet, clock, reset,
      state_ff == S_CLEAR, !rsp_valid_ff,
      "response during clear pass")

endmodule
